// ----- hw/rtl/ufc_pkg.sv -----
package ufc_pkg;

  // default receive buffer depth
  localparam int DEPTH_DEF = 64;

  // field widths
  localparam int CMD_W   = 3;
  localparam int BYTE_W  = 8;
  localparam int MARK_W  = 7;
  localparam int CFG_IDX_W = 1;
  localparam int FILL_W_DEF = $clog2(DEPTH_DEF + 1);

  // request commands
  localparam logic [CMD_W-1:0] CMD_RX_BYTE = 3'd0;
  localparam logic [CMD_W-1:0] CMD_POP     = 3'd1;
  localparam logic [CMD_W-1:0] CMD_SEND    = 3'd2;
  localparam logic [CMD_W-1:0] CMD_TX_EMPTY = 3'd3;
  localparam logic [CMD_W-1:0] CMD_RTS     = 3'd4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_MARK = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_MARK  = 1'd1;

  // mark reset values
  localparam logic [MARK_W-1:0] HIGH_MARK_RST = 7'd59;
  localparam logic [MARK_W-1:0] LOW_MARK_RST  = 7'd16;

  // per-request result flags, without the popped byte and the fill level
  typedef struct packed {
    logic              rx_valid;
    logic              tx_valid;
    logic [BYTE_W-1:0] tx_data;
    logic              want_more;
    logic              cts;
    logic              overflow;
  } ufc_res_t;

endpackage

// ----- hw/rtl/ufc_if.sv -----
interface ufc_in_if import ufc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [BYTE_W-1:0] data;
  logic              rts;

  modport source (output valid, output cmd, output data, output rts, input ready);
  modport sink   (input valid, input cmd, input data, input rts, output ready);
endinterface

interface ufc_out_if import ufc_pkg::*; #(
  parameter int CNT_W = FILL_W_DEF
) ();
  logic              valid;
  logic              ready;
  logic              rx_valid;
  logic [BYTE_W-1:0] rx_data;
  logic              tx_valid;
  logic [BYTE_W-1:0] tx_data;
  logic              want_more;
  logic              cts;
  logic              overflow;
  logic [CNT_W-1:0]  fill_level;

  modport source (
    output valid, output rx_valid, output rx_data, output tx_valid, output tx_data,
    output want_more, output cts, output overflow, output fill_level, input ready
  );
  modport sink (
    input valid, input rx_valid, input rx_data, input tx_valid, input tx_data,
    input want_more, input cts, input overflow, input fill_level, output ready
  );
endinterface

// ----- hw/rtl/ufc_ram.sv -----
module ufc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- hw/rtl/ufc_ctrl.sv -----
module ufc_ctrl import ufc_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // accepted request
  input  logic                           accept,
  input  logic [CMD_W-1:0]               cmd,
  input  logic [BYTE_W-1:0]              data,
  input  logic                           rts,
  // configuration writes
  input  logic                           cfg_we,
  input  logic [CFG_IDX_W-1:0]           cfg_idx,
  input  logic [MARK_W-1:0]              cfg_data,
  // buffer memory
  output logic                           mem_we,
  output logic [$clog2(DEPTH)-1:0]       mem_waddr,
  output logic [BYTE_W-1:0]              mem_wdata,
  output logic                           mem_re,
  output logic [$clog2(DEPTH)-1:0]       mem_raddr,
  // result of this request
  output ufc_res_t                       res,
  output logic [$clog2(DEPTH+1)-1:0]     fill
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (CNT_W > MARK_W) ? CNT_W : MARK_W;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  logic [PTR_W-1:0]  wptr_r, wptr_nxt;
  logic [PTR_W-1:0]  rptr_r, rptr_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              cts_r, cts_nxt;
  logic [BYTE_W-1:0] held_r, held_nxt;
  logic              held_v_r, held_v_nxt;
  logic              paused_r, paused_nxt;
  logic [MARK_W-1:0] high_r, low_r;
  logic              we_c, re_c;

  // next state and result for one request
  always_comb begin
    wptr_nxt   = wptr_r;
    rptr_nxt   = rptr_r;
    cnt_nxt    = cnt_r;
    cts_nxt    = cts_r;
    held_nxt   = held_r;
    held_v_nxt = held_v_r;
    paused_nxt = paused_r;
    we_c       = 1'b0;
    re_c       = 1'b0;
    res        = '0;
    case (cmd)
      CMD_RX_BYTE: begin
        if (cnt_r == CNT_FULL) begin
          res.overflow = 1'b1;
        end else begin
          we_c     = 1'b1;
          wptr_nxt = (wptr_r == PTR_LAST) ? '0 : wptr_r + 1'b1;
          cnt_nxt  = cnt_r + 1'b1;
          if (CMP_W'(cnt_nxt) > CMP_W'(high_r)) begin
            cts_nxt = 1'b1;
          end
        end
      end
      CMD_POP: begin
        if (cnt_r != '0) begin
          res.rx_valid = 1'b1;
          re_c         = 1'b1;
          rptr_nxt     = (rptr_r == PTR_LAST) ? '0 : rptr_r + 1'b1;
          cnt_nxt      = cnt_r - 1'b1;
          if (CMP_W'(cnt_nxt) < CMP_W'(low_r)) begin
            cts_nxt = 1'b0;
          end
        end
      end
      CMD_SEND: begin
        held_nxt   = data;
        held_v_nxt = 1'b1;
        if (rts) begin
          paused_nxt = 1'b1;
        end
      end
      CMD_TX_EMPTY: begin
        if (!paused_r) begin
          if (held_v_r) begin
            held_v_nxt   = 1'b0;
            res.tx_valid = 1'b1;
            res.tx_data  = held_r;
          end else begin
            res.want_more = 1'b1;
          end
        end
      end
      CMD_RTS: begin
        if (!rts && paused_r) begin
          paused_nxt = 1'b0;
          held_v_nxt = 1'b1;
        end
      end
      default: begin
      end
    endcase
    res.cts = cts_nxt;
  end

  assign fill      = cnt_nxt;
  assign mem_we    = accept && we_c;
  assign mem_waddr = wptr_r;
  assign mem_wdata = data;
  assign mem_re    = accept && re_c;
  assign mem_raddr = rptr_r;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r   <= '0;
      rptr_r   <= '0;
      cnt_r    <= '0;
      cts_r    <= 1'b0;
      held_r   <= '0;
      held_v_r <= 1'b0;
      paused_r <= 1'b0;
    end else if (accept) begin
      wptr_r   <= wptr_nxt;
      rptr_r   <= rptr_nxt;
      cnt_r    <= cnt_nxt;
      cts_r    <= cts_nxt;
      held_r   <= held_nxt;
      held_v_r <= held_v_nxt;
      paused_r <= paused_nxt;
    end
  end

  // watermark registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      high_r <= HIGH_MARK_RST;
      low_r  <= LOW_MARK_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_HIGH_MARK: high_r <= cfg_data;
        CFG_LOW_MARK:  low_r  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

endmodule

// ----- hw/rtl/uart_flow_control_buffer.sv -----
// Latency: the result of a request is valid the cycle after the request is accepted.
// Throughput: one request per cycle while out_ch is not stalled; the receive buffer has one write and one
// registered read port, and the popped byte comes straight from its read register.
// Reset (rst_n, synchronous): pointers, fill count, cts, pending byte and pause clear,
// marks return to 59 and 16; buffer contents are not cleared.
module uart_flow_control_buffer import ufc_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  ufc_in_if.sink                in_ch,
  ufc_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [MARK_W-1:0]     cfg_data
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic              accept;
  logic              mem_we, mem_re;
  logic [PTR_W-1:0]  mem_waddr, mem_raddr;
  logic [BYTE_W-1:0] mem_wdata, mem_rdata;
  ufc_res_t          res, res_r;
  logic [CNT_W-1:0]  fill, fill_r;
  logic              out_v_r;

  // request handshake
  assign in_ch.ready = !out_v_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  ufc_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .cmd       (in_ch.cmd),
    .data      (in_ch.data),
    .rts       (in_ch.rts),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_data  (cfg_data),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .res       (res),
    .fill      (fill)
  );

  ufc_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (accept) begin
      out_v_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_r  <= res;
      fill_r <= fill;
    end
  end

  // popped byte comes from the memory read register, which holds until the next pop
  assign out_ch.valid      = out_v_r;
  assign out_ch.rx_valid   = res_r.rx_valid;
  assign out_ch.rx_data    = res_r.rx_valid ? mem_rdata : '0;
  assign out_ch.tx_valid   = res_r.tx_valid;
  assign out_ch.tx_data    = res_r.tx_data;
  assign out_ch.want_more  = res_r.want_more;
  assign out_ch.cts        = res_r.cts;
  assign out_ch.overflow   = res_r.overflow;
  assign out_ch.fill_level = fill_r;

endmodule
